/* sv/pvtf_pkg.sv */
// ----------------------------------------------------------------------------
// pvtf_pkg
// Shared constants and types of the true-frequency estimator.
// ----------------------------------------------------------------------------
package pvtf_pkg;

  localparam int CHANNELS = 8;
  localparam int BINS     = 128;
  localparam int DEPTH    = CHANNELS * BINS;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int CH_W     = 3;
  localparam int BIN_W    = 7;
  localparam int PHASE_W  = 16;
  localparam int RATE_W   = 18;
  localparam int FREQ_W   = 22;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam int X_W      = BIN_W + PHASE_W;
  localparam int PROD_W   = X_W + RATE_W + 1;
  localparam int FREQ_SH  = 19;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [PHASE_W-1:0]   wdata;
  } store_req_t;

endpackage

/* sv/phase_vocoder_true_frequency.sv */
// ----------------------------------------------------------------------------
// phase_vocoder_true_frequency
// True-frequency estimator for phase-vocoder bins at 50% overlap.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one spectrum bin per request: channel, bin index
// and phase as a binary angle. Output stream m_axis returns one true frequency
// per request, in sixteenths of a hertz, in input order.
// The cfg channel writes the sample rate; it is always ready and takes effect
// for the next request. Write it only while no request is in flight.
// Throughput: one request per cycle while the receiver keeps up and the
// clearing pass is over. A request passes three registered stages: memory
// read, deviation, multiply into the output register.
// The rate is set by the single read-before-write port of the phase memory,
// which reads the old phase and writes the new one in the same cycle.
// After reset all 1024 entries of the phase memory are cleared, one per
// cycle; s_axis_tready stays low during that pass while cfg writes are taken.
// When the receiver stalls, the output register holds and the stages behind
// it fill; s_axis_tready drops once all three stages are occupied.
// ----------------------------------------------------------------------------
module phase_vocoder_true_frequency (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] channel, [9:3] bin, [25:10] phase, [31:26] zero
  input  logic [pvtf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [21:0] true_freq, [23:22] zero
  output logic [pvtf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pvtf_pkg::RATE_W-1:0]       cfg_data_i
);
  import pvtf_pkg::*;

  logic [CH_W-1:0]    ch;
  logic [BIN_W-1:0]   bin;
  logic [PHASE_W-1:0] phase;
  logic               acc;
  logic               store_ready;
  logic               pipe_ready;
  logic [PHASE_W-1:0] old_phase;
  logic [RATE_W-1:0]  rate_q;
  logic [FREQ_W-1:0]  true_freq;
  store_req_t         req;

  assign ch    = s_axis_tdata[CH_W-1:0];
  assign bin   = s_axis_tdata[CH_W +: BIN_W];
  assign phase = s_axis_tdata[CH_W + BIN_W +: PHASE_W];

  assign s_axis_tready = store_ready && pipe_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign req.en    = acc;
  assign req.addr  = ADDR_W'((32'(ch) % CHANNELS) * BINS + (32'(bin) % BINS));
  assign req.wdata = phase;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  pvtf_phase_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (old_phase),
    .ready_o (store_ready)
  );

  pvtf_freq_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .bin_i         (bin),
    .phase_i       (phase),
    .old_phase_i   (old_phase),
    .sample_rate_i (rate_q),
    .out_ready_i   (m_axis_tready),
    .in_ready_o    (pipe_ready),
    .out_valid_o   (m_axis_tvalid),
    .true_freq_o   (true_freq)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-FREQ_W){1'b0}}, true_freq};

`ifndef SYNTH
  a_hold_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !store_ready |-> !s_axis_tready)
    else $error("input taken during clearing pass");
`endif

endmodule

/* sv/pvtf_phase_store.sv */
// ----------------------------------------------------------------------------
// pvtf_phase_store
// Last-phase memory with read-before-write port and clearing pass at reset.
// ----------------------------------------------------------------------------
module pvtf_phase_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pvtf_pkg::store_req_t          req_i,
  output logic [pvtf_pkg::PHASE_W-1:0]  rdata_o,
  output logic                          ready_o
);
  import pvtf_pkg::*;

  logic [PHASE_W-1:0] mem [DEPTH];
  logic [PHASE_W-1:0] rdata_q;
  logic               clr_q, clr_d;
  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [PHASE_W-1:0] wdata;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_q || req_i.en;
  assign waddr = clr_q ? clr_addr_q : req_i.addr;
  assign wdata = clr_q ? '0 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_q;

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !req_i.en)
    else $error("request during clearing pass");
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_q |=> !clr_q)
    else $error("clearing pass restarted");
`endif

endmodule

/* sv/pvtf_freq_pipe.sv */
// ----------------------------------------------------------------------------
// pvtf_freq_pipe
// Phase deviation, offset by bin and scaling by sample rate, with output stage.
// ----------------------------------------------------------------------------
module pvtf_freq_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [pvtf_pkg::BIN_W-1:0]    bin_i,
  input  logic [pvtf_pkg::PHASE_W-1:0]  phase_i,
  input  logic [pvtf_pkg::PHASE_W-1:0]  old_phase_i,
  input  logic [pvtf_pkg::RATE_W-1:0]   sample_rate_i,
  input  logic                          out_ready_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output logic [pvtf_pkg::FREQ_W-1:0]   true_freq_o
);
  import pvtf_pkg::*;

  logic                      v1_q, v2_q, v3_q;
  logic                      en1, en2, en3;
  logic [BIN_W-1:0]          bin_q;
  logic [PHASE_W-1:0]        phase_q;
  logic [PHASE_W-1:0]        dev;
  logic signed [X_W-1:0]     x_d, x_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign dev = phase_q - old_phase_i - {bin_q[0], {(PHASE_W-1){1'b0}}};
  assign x_d = $signed({1'b0, bin_q, {(PHASE_W-1){1'b0}}})
             + $signed({{(X_W-PHASE_W){dev[PHASE_W-1]}}, dev});
  assign prod_d = x_q * $signed({1'b0, sample_rate_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= acc_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      bin_q   <= bin_i;
      phase_q <= phase_i;
    end
    if (en2 && v1_q) x_q    <= x_d;
    if (en3 && v2_q) prod_q <= prod_d;
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign true_freq_o = prod_q[FREQ_SH +: FREQ_W];

`ifndef SYNTH
  a_acc_loads_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |=> v1_q)
    else $error("accepted request lost at first stage");
  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> v2_q)
    else $error("second stage dropped a stalled request");
`endif

endmodule

/* sim/phase_vocoder_true_frequency_test.sv */
// ----------------------------------------------------------------------------
// phase_vocoder_true_frequency_test
// Self-checking bench for the phase-vocoder true-frequency estimator.
// ----------------------------------------------------------------------------
// A directed table of bins runs first at the reset sample rate, with the
// frequency typed in where it follows plainly from a cleared phase store.
// Random frames follow under several sample rates, extremes among them.
// Most frames carry tone-like phase advances; the rest are random bins.
// A local phase store and rate predict each frequency, and results are
// compared in order. Both stream sides idle at random, the receiver holds off
// for long stretches to back the pipeline up, and the sender drains the block
// before every rate change.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phase_vocoder_true_frequency_test;
  import pvtf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int FRAME_ITEMS = 72;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [CH_W-1:0]    chan;
    logic [BIN_W-1:0]   bin_idx;
    logic [PHASE_W-1:0] phase;
    logic               typed;
    logic [FREQ_W-1:0]  freq;
  } probe_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [RATE_W-1:0]     cfg_data_i    = '0;

  logic [PHASE_W-1:0] phase_store [0:DEPTH-1];
  logic [RATE_W-1:0]  rate_model;
  logic [FREQ_W-1:0]  freq_q [$];
  bit                 tx_idle;
  bit                 rx_idle;
  int                 mismatches;
  int                 bins_sent;
  int                 freqs_taken;
  int                 rate_settings;
  int                 cycles;

  probe_t probes [0:19] = '{
    '{3'd0, 7'd0,   16'h0000, 1'b1, 22'sd0},
    '{3'd0, 7'd0,   16'h8000, 1'b1, -22'sd3000},
    '{3'd0, 7'd0,   16'h7FFF, 1'b0, 22'sd0},
    '{3'd7, 7'd127, 16'h7FFF, 1'b1, 22'sd380999},
    '{3'd7, 7'd127, 16'h8000, 1'b0, 22'sd0},
    '{3'd3, 7'd1,   16'h8000, 1'b1, 22'sd3000},
    '{3'd3, 7'd1,   16'h8000, 1'b1, 22'sd0},
    '{3'd3, 7'd1,   16'h0000, 1'b0, 22'sd0},
    '{3'd1, 7'd2,   16'h0001, 1'b0, 22'sd0},
    '{3'd2, 7'd64,  16'h4000, 1'b0, 22'sd0},
    '{3'd4, 7'd126, 16'hC000, 1'b0, 22'sd0},
    '{3'd5, 7'd63,  16'hFFFF, 1'b0, 22'sd0},
    '{3'd6, 7'd85,  16'h5555, 1'b0, 22'sd0},
    '{3'd6, 7'd42,  16'hAAAA, 1'b0, 22'sd0},
    '{3'd1, 7'd2,   16'h8001, 1'b0, 22'sd0},
    '{3'd7, 7'd0,   16'h8000, 1'b1, -22'sd3000},
    '{3'd2, 7'd127, 16'h0000, 1'b1, 22'sd378000},
    '{3'd5, 7'd0,   16'h7FFF, 1'b1, 22'sd2999},
    '{3'd4, 7'd1,   16'h0000, 1'b1, 22'sd0},
    '{3'd0, 7'd127, 16'h8000, 1'b1, 22'sd381000}
  };

  phase_vocoder_true_frequency uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [FREQ_W-1:0] predict_freq(input logic [CH_W-1:0] chan,
                                                     input logic [BIN_W-1:0] bin_idx,
                                                     input logic [PHASE_W-1:0] phase);
    logic [PHASE_W-1:0] old;
    logic [PHASE_W-1:0] dev;
    int                 offset;
    longint             prod;
    old = phase_store[{chan, bin_idx}];
    phase_store[{chan, bin_idx}] = phase;
    dev = phase - old - {bin_idx[0], 15'b0};
    offset = (int'(bin_idx) <<< 15) + int'($signed(dev));
    prod = longint'(offset) * longint'(rate_model);
    return FREQ_W'(prod >>> FREQ_SH);
  endfunction

  task automatic send_bin(input logic [CH_W-1:0] chan, input logic [BIN_W-1:0] bin_idx,
                          input logic [PHASE_W-1:0] phase, input logic typed,
                          input logic [FREQ_W-1:0] typed_freq);
    logic [FREQ_W-1:0] freq;
    int                gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, phase, bin_idx, chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    freq = predict_freq(chan, bin_idx, phase);
    freq_q.push_back(typed ? typed_freq : freq);
    bins_sent++;
    gap = tx_idle ? int'($urandom_range(0, 15)) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    while (freq_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] rate);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rate;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    rate_model = rate;
    rate_settings++;
  endtask

  // mostly tone-like frames: advance each bin by its hop plus a small deviation
  task automatic send_frames(input int count);
    int                 sent;
    int                 run;
    logic [CH_W-1:0]    chan;
    logic [BIN_W-1:0]   bin_idx;
    logic [PHASE_W-1:0] dev;
    sent = 0;
    tx_idle = $urandom_range(0, 3) != 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        chan    = CH_W'($urandom_range(0, CHANNELS - 1));
        bin_idx = BIN_W'($urandom_range(0, BINS - 1));
        run     = int'($urandom_range(1, 8));
        for (int k = 0; k < run && sent < count; k++) begin
          dev = ($urandom_range(0, 15) == 0) ? 16'h8000
                                             : PHASE_W'($urandom_range(0, 4095) - 2048);
          send_bin(chan, bin_idx,
                   phase_store[{chan, bin_idx}] + {bin_idx[0], 15'b0} + dev, 1'b0, '0);
          bin_idx++;
          sent++;
        end
      end else begin
        send_bin(CH_W'($urandom_range(0, 7)), BIN_W'($urandom_range(0, 127)),
                 PHASE_W'($urandom_range(0, 65535)), 1'b0, '0);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [RATE_W-1:0] rates [0:5];
    foreach (phase_store[i]) phase_store[i] = '0;
    rate_model = RATE_RESET;
    rates = '{18'd8000, 18'd192000, 18'd0, 18'h3FFFF, 18'd44100,
              RATE_W'($urandom_range(8000, 192000))};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle = 1'b1;
    foreach (probes[i])
      send_bin(probes[i].chan, probes[i].bin_idx, probes[i].phase, probes[i].typed,
               probes[i].freq);
    s_axis_tvalid <= 1'b0;
    settle();
    foreach (rates[i]) begin
      write_rate(rates[i]);
      send_frames(FRAME_ITEMS);
      settle();
    end
    $display("%0d bins sent over %0d rate settings plus the reset rate, %0d frequencies checked",
             bins_sent, rate_settings, freqs_taken);
    if (mismatches == 0) begin
      $display("phase_vocoder_true_frequency_test passed");
    end else begin
      $display("phase_vocoder_true_frequency_test failed");
    end
    $finish;
  end

  // receiver: random stalls, two long hold-offs to back the pipeline up
  initial begin
    int wait_cycles;
    int taken;
    taken = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) rx_idle = $urandom_range(0, 2) != 0;
      if (taken == 150 || taken == 350) wait_cycles = LONG_HOLD;
      else wait_cycles = rx_idle ? int'($urandom_range(0, 15)) : 0;
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    logic [FREQ_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      freqs_taken++;
      if (freq_q.size() == 0) begin
        mismatches++;
        $display("%0t: unrequested frequency, expected none, got %0d", $time,
                 $signed(m_axis_tdata[FREQ_W-1:0]));
      end else begin
        want = freq_q.pop_front();
        if (m_axis_tdata[FREQ_W-1:0] !== want) begin
          mismatches++;
          $display("%0t: true_freq expected %0d, got %0d", $time, $signed(want),
                   $signed(m_axis_tdata[FREQ_W-1:0]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d frequencies outstanding", $time, freq_q.size());
      $display("phase_vocoder_true_frequency_test failed");
      $finish;
    end
  end

endmodule

/* files.f */
sv/pvtf_pkg.sv
sv/pvtf_phase_store.sv
sv/pvtf_freq_pipe.sv
sv/phase_vocoder_true_frequency.sv
sim/phase_vocoder_true_frequency_test.sv
